[rtl/core/ppvl_pkg.sv]
// Package for the pure-pursuit velocity law pipeline.
// Holds field widths, fixed-point constants, register indexes and the stage sideband types.
// Depends on nothing; every other file in rtl/core but ppvl_udiv imports it.
package ppvl_pkg;

	// Field and datapath widths.
	localparam int SPD_W    = 15;             // speeds and angular magnitudes
	localparam int CRD_W    = 18;             // signed target coordinates
	localparam int RAD_W    = 17;             // minimum turn radius
	localparam int ANG_W    = 16;             // signed angular rate
	localparam int D2_W     = 36;             // squared distance
	localparam int DEN_W    = CRD_W + RAD_W;  // |y| * radius
	localparam int CGN_W    = 11;             // curvature gain of 2000
	localparam int AYK_W    = 29;             // |y| * 2000
	localparam int SGN_W    = 25;             // straight-line gain of 2e7
	localparam int SPR_W    = SGN_W + CRD_W;  // straight-line test product
	localparam int NUM1_W   = SPD_W + D2_W;   // speed * d2
	localparam int NUM2_W   = SPD_W + AYK_W;  // speed * 2000 * |y|
	localparam int CFG_W    = 17;             // widest register
	localparam int CFG_IDX_W = 2;

	// Stream packing widths.
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 2'd2;

	// Register values after reset.
	localparam logic [SPD_W-1:0] RST_MIN_SPEED  = 15'd2000;
	localparam logic [SPD_W-1:0] RST_MAX_RATE   = 15'd1500;
	localparam logic [RAD_W-1:0] RST_MIN_RADIUS = 17'd2000;

	// Fixed-point constants of the law.
	localparam logic [D2_W-1:0]  STOP_D2       = 36'd100;
	localparam logic [D2_W-1:0]  NEAR_D2       = 36'd62500;
	localparam logic [SPD_W-1:0] NEAR_CAP      = 15'd1000;
	localparam logic [SGN_W-1:0] STRAIGHT_GAIN = 25'd20000000;
	localparam logic [CGN_W-1:0] CURV_GAIN     = 11'd2000;
	localparam logic [SPD_W-1:0] BOOST_LOW     = 15'd400;
	localparam logic [SPD_W-1:0] BOOST_HIGH    = 15'd900;
	localparam logic [SPD_W-1:0] BOOST_ADD     = 15'd500;
	localparam logic [SPD_W-1:0] SPD_MAX       = 15'h7FFF;

	typedef logic [SPD_W-1:0] spd_t;
	typedef logic [D2_W-1:0]  d2_t;

	// Sideband from the front end to the speed-scaling divider.
	typedef struct packed {
		spd_t              lin;
		d2_t               d2;
		logic [AYK_W-1:0]  ayk;
		logic              yneg;
		logic              stop;
		logic              straight;
		logic              scale;
	} fr_side_t;

	// Sideband from the middle section to the curvature divider.
	typedef struct packed {
		spd_t lin;
		logic yneg;
		logic stop;
		logic straight;
		logic sat;
	} md_side_t;

	// One result item; the last field sits in the lowest bits.
	typedef struct packed {
		logic                     halted;
		logic signed [ANG_W-1:0]  ang;
		spd_t                     lin;
	} res_t;

endpackage

[rtl/core/ppvl_udiv.sv]
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Carries a sideband word alongside; stand-alone, no package needed.
module ppvl_udiv #(
	parameter int NUM_W  = 51,
	parameter int DEN_W  = 36,
	parameter int QUO_W  = 15,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_vld,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int REM_W = DEN_W + QUO_W;

	// One register set per quotient bit; the numerator is assumed below den << QUO_W.
	logic              vld_s  [1:QUO_W];
	logic [REM_W-1:0]  rem_s  [1:QUO_W];
	logic [DEN_W-1:0]  den_s  [1:QUO_W];
	logic [QUO_W-1:0]  quo_s  [1:QUO_W];
	logic [SIDE_W-1:0] side_s [1:QUO_W];

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		localparam int SH = QUO_W - k;

		logic              vld_p;
		logic [REM_W-1:0]  rem_p;
		logic [DEN_W-1:0]  den_p;
		logic [QUO_W-1:0]  quo_p;
		logic [SIDE_W-1:0] side_p;
		logic [REM_W-1:0]  trial;
		logic              take;

		// The first stage reads the inputs, every later one its predecessor.
		if (k == 1) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = REM_W'(num);
			assign den_p  = den;
			assign quo_p  = '0;
			assign side_p = side;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign side_p = side_s[k-1];
		end

		// Compare the remainder with the shifted divisor and subtract when it fits.
		assign trial = REM_W'(den_p) << SH;
		assign take  = (rem_p >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? (rem_p - trial) : rem_p;
				den_s[k]  <= den_p;
				quo_s[k]  <= {quo_p[QUO_W-2:0], take};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign quo      = quo_s[QUO_W];
	assign out_side = side_s[QUO_W];

endmodule

[rtl/core/ppvl_front.sv]
// Front end: magnitudes, squared distance, halt, straight and radius tests, speed cap.
// Five register stages; depends on ppvl_pkg.
module ppvl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_vld,
	input  ppvl_pkg::spd_t                    desired_speed,
	input  logic signed [ppvl_pkg::CRD_W-1:0] target_x,
	input  logic signed [ppvl_pkg::CRD_W-1:0] target_y,
	input  logic [ppvl_pkg::RAD_W-1:0]        min_radius,
	output logic                              out_vld,
	output logic [ppvl_pkg::NUM1_W-1:0]       num1,
	output ppvl_pkg::d2_t                     den2,
	output ppvl_pkg::fr_side_t                side
);
	import ppvl_pkg::*;

	logic [CRD_W-1:0] ax_c, ay_c;
	logic             near_c;
	spd_t             lin_c;

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	spd_t             v_s1, v_s2, v_s3;
	logic [CRD_W-1:0] ax_s1, ay_s1;
	logic             yneg_s1, yneg_s2, yneg_s3;
	d2_t              ax2_s2, ay2_s2;
	logic [SPR_W-1:0] spr_s2, spr_s3;
	logic [DEN_W-1:0] den_s2;
	logic [AYK_W-1:0] ayk_s2, ayk_s3;
	d2_t              d2_s3, den2_s3, den2_s4, den2_s5;
	fr_side_t         side_s4, side_s5;
	logic [NUM1_W-1:0] num1_s5;

	// Magnitudes of the coordinates; the most negative code maps to its true magnitude.
	assign ax_c = target_x[CRD_W-1] ? CRD_W'(-target_x) : CRD_W'(target_x);
	assign ay_c = target_y[CRD_W-1] ? CRD_W'(-target_y) : CRD_W'(target_y);

	// Near-target cap on the desired speed.
	assign near_c = (d2_s3 < NEAR_D2);
	assign lin_c  = (near_c && (v_s3 > NEAR_CAP)) ? NEAR_CAP : v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: magnitudes.
			v_s1    <= desired_speed;
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			yneg_s1 <= target_y[CRD_W-1];

			// Stage 2: squares and the products with |y|.
			v_s2    <= v_s1;
			ax2_s2  <= D2_W'(ax_s1) * D2_W'(ax_s1);
			ay2_s2  <= D2_W'(ay_s1) * D2_W'(ay_s1);
			spr_s2  <= SPR_W'(STRAIGHT_GAIN) * SPR_W'(ay_s1);
			den_s2  <= DEN_W'(ay_s1) * DEN_W'(min_radius);
			ayk_s2  <= AYK_W'(ay_s1) * AYK_W'(CURV_GAIN);
			yneg_s2 <= yneg_s1;

			// Stage 3: squared distance and doubled radius product.
			v_s3    <= v_s2;
			d2_s3   <= ax2_s2 + ay2_s2;
			spr_s3  <= spr_s2;
			den2_s3 <= {den_s2, 1'b0};
			ayk_s3  <= ayk_s2;
			yneg_s3 <= yneg_s2;

			// Stage 4: distance tests and the capped speed.
			side_s4.lin      <= lin_c;
			side_s4.d2       <= d2_s3;
			side_s4.ayk      <= ayk_s3;
			side_s4.yneg     <= yneg_s3;
			side_s4.stop     <= (d2_s3 < STOP_D2);
			side_s4.straight <= (spr_s3 < SPR_W'(d2_s3));
			side_s4.scale    <= (d2_s3 < den2_s3);
			den2_s4          <= den2_s3;

			// Stage 5: numerator of the radius scaling.
			num1_s5 <= NUM1_W'(side_s4.lin) * NUM1_W'(side_s4.d2);
			den2_s5 <= den2_s4;
			side_s5 <= side_s4;
		end
	end

	assign out_vld = vld_s5;
	assign num1    = num1_s5;
	assign den2    = den2_s5;
	assign side    = side_s5;

endmodule

[rtl/core/ppvl_mid.sv]
// Middle section between the two dividers: scaled speed, floor, curvature numerator.
// Three register stages; depends on ppvl_pkg.
module ppvl_mid (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  ppvl_pkg::spd_t              quo,
	input  ppvl_pkg::fr_side_t          side,
	input  ppvl_pkg::spd_t              min_speed,
	output logic                        out_vld,
	output logic [ppvl_pkg::NUM2_W-1:0] num2,
	output ppvl_pkg::d2_t               d2,
	output ppvl_pkg::md_side_t          out_side
);
	import ppvl_pkg::*;

	spd_t              sel_c, lin2_c;
	logic              vld_s1, vld_s2, vld_s3;
	spd_t              lin2_s1;
	logic [AYK_W-1:0]  ayk_s1;
	d2_t               d2_s1, d2_s2, d2_s3;
	md_side_t          side_s1, side_s2, side_s3;
	logic [NUM2_W-1:0] num2_s2, num2_s3;

	// Radius-scaled speed when the turn is tight, then the speed floor.
	assign sel_c  = side.scale ? quo : side.lin;
	assign lin2_c = (sel_c < min_speed) ? min_speed : sel_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: commanded speed; a straight path keeps the capped speed.
			lin2_s1           <= lin2_c;
			ayk_s1            <= side.ayk;
			d2_s1             <= side.d2;
			side_s1.lin       <= side.straight ? side.lin : lin2_c;
			side_s1.yneg      <= side.yneg;
			side_s1.stop      <= side.stop;
			side_s1.straight  <= side.straight;
			side_s1.sat       <= 1'b0;

			// Stage 2: speed times 2000 * |y|.
			num2_s2 <= NUM2_W'(lin2_s1) * NUM2_W'(ayk_s1);
			d2_s2   <= d2_s1;
			side_s2 <= side_s1;

			// Stage 3: flag quotients that would not fit the angular field.
			num2_s3          <= num2_s2;
			d2_s3            <= d2_s2;
			side_s3.lin      <= side_s2.lin;
			side_s3.yneg     <= side_s2.yneg;
			side_s3.stop     <= side_s2.stop;
			side_s3.straight <= side_s2.straight;
			side_s3.sat      <= (NUM1_W'(num2_s2) >= {d2_s2, {SPD_W{1'b0}}});
		end
	end

	assign out_vld  = vld_s3;
	assign num2     = num2_s3;
	assign d2       = d2_s3;
	assign out_side = side_s3;

endmodule

[rtl/core/ppvl_back.sv]
// Back end: angular clamp, low-rate boost, sign and final selection of the result.
// Two register stages; depends on ppvl_pkg.
module ppvl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  ppvl_pkg::spd_t     quo,
	input  ppvl_pkg::md_side_t side,
	input  ppvl_pkg::spd_t     max_rate,
	output logic               out_vld,
	output ppvl_pkg::res_t     res
);
	import ppvl_pkg::*;

	spd_t                    mag_c, bst_c;
	logic signed [ANG_W-1:0] ext_c, ang_c;
	logic                    vld_s1, vld_s2;
	spd_t                    mag_s1;
	md_side_t                side_s1;
	res_t                    res_s2;

	// A saturated quotient is no smaller than any clamp value.
	assign mag_c = side.sat ? SPD_MAX : quo;

	// Rates in the dead band get a fixed boost, then the sign of y.
	assign bst_c = ((mag_s1 > BOOST_LOW) && (mag_s1 < BOOST_HIGH)) ? (mag_s1 + BOOST_ADD) : mag_s1;
	assign ext_c = ANG_W'(bst_c);
	assign ang_c = side_s1.yneg ? -ext_c : ext_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: clamp to the configured maximum.
			mag_s1  <= (mag_c > max_rate) ? max_rate : mag_c;
			side_s1 <= side;

			// Stage 2: a close target halts, a straight path gives no rotation.
			if (side_s1.stop) begin
				res_s2.lin    <= '0;
				res_s2.ang    <= '0;
				res_s2.halted <= 1'b1;
			end else if (side_s1.straight) begin
				res_s2.lin    <= side_s1.lin;
				res_s2.ang    <= '0;
				res_s2.halted <= 1'b0;
			end else begin
				res_s2.lin    <= side_s1.lin;
				res_s2.ang    <= ang_c;
				res_s2.halted <= 1'b0;
			end
		end
	end

	assign out_vld = vld_s2;
	assign res     = res_s2;

endmodule

[rtl/core/pure_pursuit_velocity_law.sv]
// Throughput: one transaction per cycle while the skid register is empty,
// set by the one-bit-per-stage pipelined dividers.
// s_tready drops only while the skid register holds a result behind a stalled output.
// Reset (arst_n, asynchronous) clears every valid bit and restores the register defaults.
// Top level of the pure-pursuit velocity law; depends on ppvl_pkg and the ppvl_* modules.
module pure_pursuit_velocity_law (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ppvl_pkg::S_TDATA_W-1:0]      s_tdata,  // desired_speed, target_x, target_y, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ppvl_pkg::M_TDATA_W-1:0]      m_tdata,  // linear_speed, angular_rate, zero pad
	output logic                                m_tuser,  // halted
	input  logic                                cfg_we,
	input  logic [ppvl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ppvl_pkg::CFG_W-1:0]          cfg_wdata
);
	import ppvl_pkg::*;

	spd_t                    min_speed_q, max_rate_q;
	logic [RAD_W-1:0]        min_radius_q;

	logic                    adv;
	spd_t                    desired_speed;
	logic signed [CRD_W-1:0] target_x, target_y;

	logic                    fr_vld, d1_vld, md_vld, d2_vld, bk_vld;
	logic [NUM1_W-1:0]       fr_num1;
	d2_t                     fr_den2, md_d2;
	fr_side_t                fr_side, d1_side;
	spd_t                    d1_quo, d2_quo;
	logic [NUM2_W-1:0]       md_num2;
	md_side_t                md_side, d2_side;
	res_t                    bk_res;

	logic                    out_vld_q, skid_vld_q;
	res_t                    out_q, skid_q;
	logic                    out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q  <= RST_MIN_SPEED;
			max_rate_q   <= RST_MAX_RATE;
			min_radius_q <= RST_MIN_RADIUS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_SPEED:  min_speed_q  <= cfg_wdata[SPD_W-1:0];
				REG_MAX_RATE:   max_rate_q   <= cfg_wdata[SPD_W-1:0];
				REG_MIN_RADIUS: min_radius_q <= cfg_wdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together while the skid register is empty.
	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	// Unpack the input transaction.
	assign desired_speed = s_tdata[SPD_W-1:0];
	assign target_x      = $signed(s_tdata[SPD_W+CRD_W-1:SPD_W]);
	assign target_y      = $signed(s_tdata[SPD_W+2*CRD_W-1:SPD_W+CRD_W]);

	ppvl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_vld        (s_tvalid),
		.desired_speed (desired_speed),
		.target_x      (target_x),
		.target_y      (target_y),
		.min_radius    (min_radius_q),
		.out_vld       (fr_vld),
		.num1          (fr_num1),
		.den2          (fr_den2),
		.side          (fr_side)
	);

	// Speed scaled by radius over minimum radius.
	ppvl_udiv #(
		.NUM_W  (NUM1_W),
		.DEN_W  (D2_W),
		.QUO_W  (SPD_W),
		.SIDE_W ($bits(fr_side_t))
	) u_div_speed (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.num      (fr_num1),
		.den      (fr_den2),
		.side     (fr_side),
		.out_vld  (d1_vld),
		.quo      (d1_quo),
		.out_side (d1_side)
	);

	ppvl_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (d1_vld),
		.quo       (d1_quo),
		.side      (d1_side),
		.min_speed (min_speed_q),
		.out_vld   (md_vld),
		.num2      (md_num2),
		.d2        (md_d2),
		.out_side  (md_side)
	);

	// Angular rate as speed times curvature.
	ppvl_udiv #(
		.NUM_W  (NUM2_W),
		.DEN_W  (D2_W),
		.QUO_W  (SPD_W),
		.SIDE_W ($bits(md_side_t))
	) u_div_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (md_vld),
		.num      (md_num2),
		.den      (md_d2),
		.side     (md_side),
		.out_vld  (d2_vld),
		.quo      (d2_quo),
		.out_side (d2_side)
	);

	ppvl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (d2_vld),
		.quo      (d2_quo),
		.side     (d2_side),
		.max_rate (max_rate_q),
		.out_vld  (bk_vld),
		.res      (bk_res)
	);

	// Output register with a skid register behind it.
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= bk_vld;
			end
		end else if (bk_vld && adv) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : bk_res;
		end else if (adv) begin
			skid_q <= bk_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(M_TDATA_W-SPD_W-ANG_W){1'b0}}, out_q.ang, out_q.lin};
	assign m_tuser  = out_q.halted;

`ifndef SYNTHESIS
	// The skid register only fills behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid register filled without an output stall");

	// A halted result carries zero commands.
	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.halted) |-> ((out_q.lin == '0) && (out_q.ang == '0)))
		else $error("halted result with non-zero command");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the pure-pursuit velocity law pipeline.
// Drives directed and random lookahead targets under several register settings and
// checks every command against the directed table or its own predictor; depends on ppvl_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

	// Fixed-point constants of the steering law, kept apart from the package.
	localparam longint unsigned HALT_DIST2     = 100;
	localparam longint unsigned SLOW_DIST2     = 62500;
	localparam longint unsigned SLOW_SPEED_CAP = 1000;
	localparam longint unsigned STRAIGHT_K     = 20000000;
	localparam longint unsigned CURVE_K        = 2000;
	localparam longint unsigned NUDGE_LOW      = 400;
	localparam longint unsigned NUDGE_HIGH     = 900;
	localparam longint unsigned NUDGE_ADD      = 500;

	localparam int DRAIN_SLACK  = 50;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 145;
	localparam int N_DIRECTED   = 23;
	localparam int N_SETTINGS   = 7;
	localparam int LONG_HOLD    = 300;
	localparam int AWAIT_DEPTH  = 64;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [ppvl_pkg::S_TDATA_W-1:0]    s_tdata;   // desired_speed, target_x, target_y, zero pad
	logic                              m_tvalid;
	logic                              m_tready;
	logic [ppvl_pkg::M_TDATA_W-1:0]    m_tdata;   // linear_speed, angular_rate, zero pad
	logic                              m_tuser;   // halted
	logic                              cfg_we;
	logic [ppvl_pkg::CFG_IDX_W-1:0]    cfg_idx;
	logic [ppvl_pkg::CFG_W-1:0]        cfg_wdata;

	pure_pursuit_velocity_law dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// One row of the directed table; the command is typed in only where marked.
	typedef struct packed {
		logic [14:0]        v;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic               typed;
		logic [14:0]        lin;
		logic signed [15:0] ang;
		logic               halted;
	} steer_row_t;

	steer_row_t directed_rows [N_DIRECTED] = '{
		// Too close: origin and just inside the halt circle.
		'{15'd0,     18'sd0,       18'sd0,       1'b1, 15'd0,     16'sd0, 1'b1},
		'{15'd30000, 18'sd9,       -18'sd4,      1'b1, 15'd0,     16'sd0, 1'b1},
		'{15'd32767, -18'sd7,      18'sd7,       1'b1, 15'd0,     16'sd0, 1'b1},
		// On the halt and near-target circles, all straight; the first row is capped.
		'{15'd30000, 18'sd10,      18'sd0,       1'b1, 15'd1000,  16'sd0, 1'b0},
		'{15'd500,   18'sd249,     18'sd0,       1'b1, 15'd500,   16'sd0, 1'b0},
		'{15'd30000, 18'sd250,     18'sd0,       1'b1, 15'd30000, 16'sd0, 1'b0},
		// Straight ahead and behind at the field extremes.
		'{15'd30000, 18'sd100000,  18'sd0,       1'b1, 15'd30000, 16'sd0, 1'b0},
		'{15'd0,     -18'sd100000, 18'sd0,       1'b1, 15'd0,     16'sd0, 1'b0},
		'{15'd32767, -18'sd131072, 18'sd0,       1'b1, 15'd32767, 16'sd0, 1'b0},
		'{15'd30000, 18'sd131071,  18'sd1,       1'b1, 15'd30000, 16'sd0, 1'b0},
		// Turning cases left to the predictor.
		'{15'd30000, 18'sd0,       -18'sd131072, 1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd32767, 18'sd131071,  18'sd131071,  1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd30000, 18'sd100,     18'sd100,     1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd30000, 18'sd100,     -18'sd100,    1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd500,   18'sd1000,    18'sd110,     1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd500,   18'sd1000,    -18'sd110,    1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd20000, 18'sd3000,    18'sd1500,    1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd0,     18'sd5000,    -18'sd2500,   1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd30000, -18'sd100000, 18'sd100000,  1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd1000,  18'sd4473,    18'sd1,       1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd1000,  18'sd4472,    18'sd1,       1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd15000, -18'sd50000,  -18'sd2000,   1'b0, 15'd0,     16'sd0, 1'b0},
		'{15'd32767, 18'sd0,       18'sd100,     1'b0, 15'd0,     16'sd0, 1'b0}
	};

	// Register settings per random phase: minimum speed, maximum rate, minimum radius.
	logic [16:0] phase_settings [N_SETTINGS][3] = '{
		'{17'd0,       17'd0,       17'd0},
		'{17'd30000,   17'd20000,   17'd100000},
		'{17'h1FFFF,   17'h1FFFF,   17'h1FFFF},
		'{17'd1,       17'd1,       17'd1},
		'{17'd500,     17'd800,     17'd5000},
		'{17'd25000,   17'd300,     17'd1},
		'{17'd2000,    17'd1500,    17'd2000}
	};

	// Local copy of the registers, as the block should hold them.
	logic [14:0] mirror_min_speed;
	logic [14:0] mirror_max_rate;
	logic [16:0] mirror_min_radius;

	// Commands still awaited, oldest at the read pointer.
	ppvl_pkg::res_t awaited_commands [AWAIT_DEPTH];
	logic [5:0]     await_wr;
	logic [5:0]     await_rd;
	int             await_count;
	ppvl_pkg::res_t drive_exp;
	logic           drive_typed;
	int             n_errors;
	int             results_seen;
	int             burst_left;
	bit             long_hold_done;

	// Velocity law: speed and angular rate for one lookahead point.
	function automatic ppvl_pkg::res_t predict_command(input logic [14:0] v,
			input logic signed [17:0] x, input logic signed [17:0] y);
		longint          sx;
		longint          sy;
		longint          sang;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned d2;
		longint unsigned lin;
		longint unsigned mag;
		longint unsigned den;
		ppvl_pkg::res_t  r;
		sx  = longint'(x);
		sy  = longint'(y);
		ax  = (sx < 0) ? -sx : sx;
		ay  = (sy < 0) ? -sy : sy;
		d2  = ax * ax + ay * ay;
		lin = 64'(v);
		r   = '0;
		if (d2 < HALT_DIST2) begin
			r.halted = 1'b1;
			return r;
		end
		if (d2 < SLOW_DIST2 && lin > SLOW_SPEED_CAP)
			lin = SLOW_SPEED_CAP;
		// Negligible curvature: straight motion, no minimum-speed floor.
		if (STRAIGHT_K * ay < d2) begin
			r.lin = lin[14:0];
			return r;
		end
		den = 2 * ay * longint'(mirror_min_radius);
		if (mirror_min_radius != 0 && d2 < den)
			lin = (lin * d2) / den;
		if (lin < longint'(mirror_min_speed))
			lin = 64'(mirror_min_speed);
		mag = (lin * CURVE_K * ay) / d2;
		if (mag > longint'(mirror_max_rate))
			mag = 64'(mirror_max_rate);
		if (mag > NUDGE_LOW && mag < NUDGE_HIGH)
			mag = mag + NUDGE_ADD;
		sang  = (sy < 0) ? -longint'(mag) : longint'(mag);
		r.lin = lin[14:0];
		r.ang = sang[15:0];
		return r;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL pure_pursuit_velocity_law");
		$finish;
	end

	// Result side: stall patterns, plus one long hold to fill the pipeline.
	initial begin : result_sink
		int span;
		int mode;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(5, 60);
			repeat (span) begin
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = ($urandom_range(0, 3) != 0);
					default: m_tready = ($urandom_range(0, 1) != 0);
				endcase
				@(negedge clk);
			end
		end
	end

	// Scoreboard: predict on each input transaction, compare on each output transaction.
	always @(posedge clk) begin : scoreboard
		ppvl_pkg::res_t want;
		ppvl_pkg::res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (drive_typed)
					awaited_commands[await_wr] = drive_exp;
				else
					awaited_commands[await_wr] = predict_command(s_tdata[14:0],
						s_tdata[32:15], s_tdata[50:33]);
				await_wr    = await_wr + 6'd1;
				await_count = await_count + 1;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.lin    = m_tdata[14:0];
				got.ang    = m_tdata[30:15];
				got.halted = m_tuser;
				if (await_count == 0) begin
					n_errors++;
					$display("%0t: result with none awaited: linear %0d angular %0d halted %0b",
						$time, got.lin, $signed(got.ang), got.halted);
				end else begin
					want        = awaited_commands[await_rd];
					await_rd    = await_rd + 6'd1;
					await_count = await_count - 1;
					if (got.lin !== want.lin) begin
						n_errors++;
						$display("%0t: linear_speed expected %0d actual %0d",
							$time, want.lin, got.lin);
					end
					if (got.ang !== want.ang) begin
						n_errors++;
						$display("%0t: angular_rate expected %0d actual %0d",
							$time, $signed(want.ang), $signed(got.ang));
					end
					if (got.halted !== want.halted) begin
						n_errors++;
						$display("%0t: halted expected %0b actual %0b",
							$time, want.halted, got.halted);
					end
				end
			end
		end
	end

	// Offer one target and hold it until the transaction completes; called at a falling edge.
	task automatic send_target(input logic [14:0] v, input logic signed [17:0] x,
			input logic signed [17:0] y, input logic typed, input ppvl_pkg::res_t exp_cmd);
		s_tdata     = {5'd0, y, x, v};
		drive_typed = typed;
		drive_exp   = exp_cmd;
		s_tvalid    = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Bursts of random length with random gaps between most of them.
	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 9) < 7) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// Stop offering and wait until every awaited command has arrived.
	task automatic drain_pipeline();
		s_tvalid = 1'b0;
		while (await_count != 0) @(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	task automatic write_register(input logic [ppvl_pkg::CFG_IDX_W-1:0] idx,
			input logic [16:0] value);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = value;
		case (idx)
			ppvl_pkg::REG_MIN_SPEED:  mirror_min_speed  = value[14:0];
			ppvl_pkg::REG_MAX_RATE:   mirror_max_rate   = value[14:0];
			ppvl_pkg::REG_MIN_RADIUS: mirror_min_radius = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Random coordinate of a span set by kind: close in, across the range, or at full width.
	function automatic logic signed [17:0] draw_coord(input int kind);
		int span;
		logic [31:0] raw;
		case (kind)
			0:       span = 12;
			1:       span = 300;
			2:       span = 20000;
			default: span = 100000;
		endcase
		raw = $urandom();
		if (kind == 4)
			return raw[17:0];
		return 18'($urandom_range(0, 2 * span) - span);
	endfunction

	// Main stimulus: directed table, then random targets under each register setting.
	initial begin : stimulus
		steer_row_t      row;
		ppvl_pkg::res_t  exp_cmd;
		logic [14:0]     v;
		logic signed [17:0] x;
		logic signed [17:0] y;
		int              pick;
		int              kind;
		arst_n            = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = '0;
		cfg_we            = 1'b0;
		cfg_idx           = ppvl_pkg::REG_MIN_SPEED;
		cfg_wdata         = '0;
		drive_typed       = 1'b0;
		drive_exp         = '0;
		await_wr          = '0;
		await_rd          = '0;
		await_count       = 0;
		n_errors          = 0;
		results_seen      = 0;
		long_hold_done    = 1'b0;
		burst_left        = $urandom_range(1, 30);
		mirror_min_speed  = 15'd2000;
		mirror_max_rate   = 15'd1500;
		mirror_min_radius = 17'd2000;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed targets under the reset values of the registers.
		for (int i = 0; i < N_DIRECTED; i++) begin
			row            = directed_rows[i];
			exp_cmd.lin    = row.lin;
			exp_cmd.ang    = row.ang;
			exp_cmd.halted = row.halted;
			send_target(row.v, row.x, row.y, row.typed, exp_cmd);
			pace_sender();
		end
		drain_pipeline();

		// Random phases; registers change only with the pipeline empty.
		for (int p = 0; p < N_SETTINGS; p++) begin
			write_register(ppvl_pkg::REG_MIN_SPEED,  phase_settings[p][0]);
			write_register(ppvl_pkg::REG_MAX_RATE,   phase_settings[p][1]);
			write_register(ppvl_pkg::REG_MIN_RADIUS, phase_settings[p][2]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 1)
					v = 15'($urandom());
				else if (pick < 2)
					v = 15'($urandom_range(0, 1500));
				else
					v = 15'($urandom_range(0, 30000));
				pick = $urandom_range(0, 99);
				kind = (pick < 10) ? 0 : (pick < 35) ? 1 : (pick < 60) ? 2 :
					(pick < 90) ? 3 : 4;
				x = draw_coord(kind);
				// Small lateral offsets against long range exercise the straight test.
				y = ($urandom_range(0, 4) == 0) ? 18'($urandom_range(0, 100) - 50) :
					draw_coord(kind);
				send_target(v, x, y, 1'b0, '0);
				pace_sender();
			end
			drain_pipeline();
		end

		if (n_errors == 0)
			$display("PASS pure_pursuit_velocity_law");
		else
			$display("FAIL pure_pursuit_velocity_law");
		$finish;
	end

endmodule

[pure_pursuit_velocity_law.f]
rtl/core/ppvl_pkg.sv
rtl/core/ppvl_udiv.sv
rtl/core/ppvl_front.sv
rtl/core/ppvl_mid.sv
rtl/core/ppvl_back.sv
rtl/core/pure_pursuit_velocity_law.sv
dv/tb.sv
